@@ hdl/wheel_encoder_pulse_velocity_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the encoder velocity block
// Each macro places one labeled concurrent assertion on the rising clock
// edge, with checks switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef WHEEL_ENCODER_PULSE_VELOCITY_ASSERT_SVH
`define WHEEL_ENCODER_PULSE_VELOCITY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WEP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ hdl/wep_pkg.sv @@
// ----------------------------------------------------------------------------
// wep_pkg
// Types and constants shared by the wheel encoder velocity block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wep_pkg;

   localparam int COUNT_W  = 32;
   localparam int TIME_W   = 32;
   localparam int CM_W     = 24;
   localparam int MIN_W    = 16;
   localparam int WINDOW_W = 16;
   localparam int VEL_W    = 32;
   localparam int DIST_W   = 48;
   localparam int CSR_W    = 24;

   // Velocity is scaled from per millisecond to per second.
   localparam int VEL_SCALE = 1000;

   typedef enum logic [1:0] {
      ACT_EDGE      = 2'd0,
      ACT_VELOCITY  = 2'd1,
      ACT_RESET     = 2'd2,
      ACT_DIRECTION = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_MIN_EDGE_US       = 2'd0,
      CSR_VELOCITY_WINDOW_MS = 2'd1,
      CSR_CM_PER_PULSE      = 2'd2
   } csr_index_type;

   localparam logic [1:0] DIR_PLUS  = 2'b01;
   localparam logic [1:0] DIR_ZERO  = 2'b00;
   localparam logic [1:0] DIR_MINUS = 2'b11;

   typedef struct packed {
      logic [MIN_W-1:0]    min_edge_us;
      logic [WINDOW_W-1:0] window_ms;
      logic [CM_W-1:0]     cm_per_pulse;
   } cfg_type;

   // One classified request on its way from the front to the back.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] delta;
      logic [TIME_W-1:0]  elapsed;
      logic               do_velocity;
      logic               clear_velocity;
   } job_type;

endpackage

@@ hdl/wheel_encoder_pulse_velocity.sv @@
// ----------------------------------------------------------------------------
// wheel_encoder_pulse_velocity
// Single-channel wheel encoder counter with windowed velocity measurement.
// ----------------------------------------------------------------------------
// Every request returns one response with the count, velocity and distance.
// A request passes back-end states ST_MUL, ST_SCALE and ST_DONE after the job
// queue; an unsaturated velocity request that passes the window also runs
// ST_DIV, the 32-step restoring divider for delta*cm_per_pulse*1000/elapsed.
// The front end accepts requests into the job queue while the back end
// works, and a finished response waits in its output register until popped.
// Configuration writes take effect on the next cycle and belong to idle time.
`timescale 1ns / 1ps

module wheel_encoder_pulse_velocity import wep_pkg::*; #(
   parameter int JOB_QUEUE_DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [1:0]                req_action,
   input  logic [TIME_W-1:0]         req_now_us,
   input  logic [TIME_W-1:0]         req_now_ms,
   input  logic signed [1:0]         req_direction,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [COUNT_W-1:0] rsp_pulse_count,
   output logic signed [VEL_W-1:0]   rsp_velocity,
   output logic signed [DIST_W-1:0]  rsp_distance,
   output logic                      rsp_velocity_updated,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   job_type front_job;
   job_type queue_job;
   logic    accept;
   logic    job_empty;
   logic    job_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_EDGE_US:        cfg_in.min_edge_us  = csr_wdata[MIN_W-1:0];
            CSR_VELOCITY_WINDOW_MS: cfg_in.window_ms    = csr_wdata[WINDOW_W-1:0];
            CSR_CM_PER_PULSE:       cfg_in.cm_per_pulse = csr_wdata[CM_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_edge_us  <= MIN_W'(100);
         cfg_ff.window_ms    <= WINDOW_W'(50);
         cfg_ff.cm_per_pulse <= CM_W'(13107);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = push && !full;

   wep_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .req_action    (req_action),
      .req_now_us    (req_now_us),
      .req_now_ms    (req_now_ms),
      .req_direction (req_direction),
      .job           (front_job)
   );

   wep_queue #(
      .DEPTH (JOB_QUEUE_DEPTH),
      .WIDTH ($bits(job_type))
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (front_job),
      .rd_en   (job_pop),
      .rd_data (queue_job),
      .q_empty (job_empty),
      .q_full  (full)
   );

   wep_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cm_per_pulse         (cfg_ff.cm_per_pulse),
      .job_empty            (job_empty),
      .job                  (queue_job),
      .job_pop              (job_pop),
      .pop                  (pop),
      .empty                (empty),
      .rsp_pulse_count      (rsp_pulse_count),
      .rsp_velocity         (rsp_velocity),
      .rsp_distance         (rsp_distance),
      .rsp_velocity_updated (rsp_velocity_updated)
   );

endmodule

@@ hdl/wep_queue.sv @@
// ----------------------------------------------------------------------------
// wep_queue
// Small register queue that parts the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wheel_encoder_pulse_velocity_assert.svh"

module wep_queue #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             q_empty,
   output logic             q_full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign rd_data = entries_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `WEP_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `WEP_ASSERT_NEXT(a_count_tracks, clock, reset, do_wr && !do_rd && !reset, !q_empty)

endmodule

@@ hdl/wep_front.sv @@
// ----------------------------------------------------------------------------
// wep_front
// Accepts requests, applies edge filtering and the velocity window, and
// keeps the count, direction and timestamp state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wep_front import wep_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                accept,
   input  logic [1:0]          req_action,
   input  logic [TIME_W-1:0]   req_now_us,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  logic signed [1:0]   req_direction,
   output job_type             job
);

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [1:0]          dir_ff, dir_in;
   logic [TIME_W-1:0]   last_edge_ff, last_edge_in;
   logic [COUNT_W-1:0]  snapshot_ff, snapshot_in;
   logic [TIME_W-1:0]   last_vel_ff, last_vel_in;
   logic [TIME_W-1:0]   edge_gap;
   logic [TIME_W-1:0]   vel_elapsed;
   logic [WINDOW_W-1:0] window;
   logic                do_velocity;
   logic                clear_velocity;

   assign edge_gap    = req_now_us - last_edge_ff;
   assign vel_elapsed = req_now_ms - last_vel_ff;
   // A zero window behaves as one millisecond.
   assign window      = (cfg.window_ms == '0) ? WINDOW_W'(1) : cfg.window_ms;

   always_comb begin
      count_in       = count_ff;
      dir_in         = dir_ff;
      last_edge_in   = last_edge_ff;
      snapshot_in    = snapshot_ff;
      last_vel_in    = last_vel_ff;
      do_velocity    = 1'b0;
      clear_velocity = 1'b0;
      if (accept) begin
         unique case (action_type'(req_action))
            ACT_EDGE: begin
               if (edge_gap >= {{(TIME_W-MIN_W){1'b0}}, cfg.min_edge_us}) begin
                  last_edge_in = req_now_us;
                  count_in     = count_ff + {{(COUNT_W-2){dir_ff[1]}}, dir_ff};
               end
            end
            ACT_VELOCITY: begin
               if (vel_elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, window}) begin
                  do_velocity = 1'b1;
                  snapshot_in = count_ff;
                  last_vel_in = req_now_ms;
               end
            end
            ACT_RESET: begin
               count_in       = '0;
               snapshot_in    = '0;
               last_vel_in    = req_now_ms;
               clear_velocity = 1'b1;
            end
            ACT_DIRECTION: begin
               // Both negative codes give a backward direction.
               unique case (req_direction)
                  DIR_PLUS: dir_in = DIR_PLUS;
                  DIR_ZERO: dir_in = DIR_ZERO;
                  default:  dir_in = DIR_MINUS;
               endcase
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      job.count          = count_in;
      job.delta          = count_ff - snapshot_ff;
      job.elapsed        = vel_elapsed;
      job.do_velocity    = do_velocity;
      job.clear_velocity = clear_velocity;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dir_ff       <= DIR_PLUS;
         last_edge_ff <= '0;
         snapshot_ff  <= '0;
         last_vel_ff  <= '0;
      end else begin
         count_ff     <= count_in;
         dir_ff       <= dir_in;
         last_edge_ff <= last_edge_in;
         snapshot_ff  <= snapshot_in;
         last_vel_ff  <= last_vel_in;
      end
   end

endmodule

@@ hdl/wep_back.sv @@
// ----------------------------------------------------------------------------
// wep_back
// Takes classified requests from the queue, forms distance by a product and
// velocity with a restoring divider, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wheel_encoder_pulse_velocity_assert.svh"

module wep_back import wep_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CM_W-1:0]          cm_per_pulse,
   input  logic                     job_empty,
   input  job_type                  job,
   output logic                     job_pop,
   input  logic                     pop,
   output logic                     empty,
   output logic signed [COUNT_W-1:0] rsp_pulse_count,
   output logic signed [VEL_W-1:0]  rsp_velocity,
   output logic signed [DIST_W-1:0] rsp_distance,
   output logic                     rsp_velocity_updated
);

   localparam int PROD_W    = COUNT_W + CM_W;
   localparam int SCALE_W   = PROD_W + $clog2(VEL_SCALE);
   localparam int HI_W      = SCALE_W - TIME_W;
   localparam int DIV_STEPS = VEL_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_SCALE = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } back_state_type;

   back_state_type     state_ff, state_in;
   job_type            job_ff, job_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  dist_ff, dist_in;
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [VEL_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               sat_ff, sat_in;
   logic [VEL_W-1:0]   velocity_ff, velocity_in;
   logic               out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [VEL_W-1:0]   out_vel_ff, out_vel_in;
   logic [DIST_W-1:0]  out_dist_ff, out_dist_in;
   logic               out_upd_ff, out_upd_in;

   logic [SCALE_W-1:0] scaled;
   logic [HI_W-1:0]    scaled_hi;
   logic [TIME_W:0]    trial;
   logic               trial_ge;
   logic [VEL_W-1:0]   vel_new;
   logic [DIST_W-1:0]  dist_sat;
   logic               out_free;

   function automatic logic [COUNT_W-1:0] magnitude(input logic [COUNT_W-1:0] v);
      return v[COUNT_W-1] ? (~v + COUNT_W'(1)) : v;
   endfunction

   assign scaled    = SCALE_W'(prod_ff) * SCALE_W'(VEL_SCALE);
   assign scaled_hi = scaled[SCALE_W-1:TIME_W];
   assign trial     = {rem_ff, quo_ff[VEL_W-1]};
   assign trial_ge  = (trial >= {1'b0, job_ff.elapsed});
   assign out_free  = !out_valid_ff || pop;

   // Apply the sign to the truncated magnitude and saturate.
   always_comb begin
      if (job_ff.delta[COUNT_W-1]) begin
         if (sat_ff || (quo_ff > {1'b1, {(VEL_W-1){1'b0}}})) begin
            vel_new = {1'b1, {(VEL_W-1){1'b0}}};
         end else begin
            vel_new = ~quo_ff + VEL_W'(1);
         end
      end else begin
         if (sat_ff || quo_ff[VEL_W-1]) begin
            vel_new = {1'b0, {(VEL_W-1){1'b1}}};
         end else begin
            vel_new = quo_ff;
         end
      end
   end

   always_comb begin
      if (job_ff.count[COUNT_W-1]) begin
         if (dist_ff > PROD_W'({1'b1, {(DIST_W-1){1'b0}}})) begin
            dist_sat = {1'b1, {(DIST_W-1){1'b0}}};
         end else begin
            dist_sat = ~dist_ff[DIST_W-1:0] + DIST_W'(1);
         end
      end else begin
         if (dist_ff > PROD_W'({1'b0, {(DIST_W-1){1'b1}}})) begin
            dist_sat = {1'b0, {(DIST_W-1){1'b1}}};
         end else begin
            dist_sat = dist_ff[DIST_W-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      prod_in      = prod_ff;
      dist_in      = dist_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      sat_in       = sat_ff;
      velocity_in  = velocity_ff;
      out_valid_in = out_valid_ff && !pop;
      out_count_in = out_count_ff;
      out_vel_in   = out_vel_ff;
      out_dist_in  = out_dist_ff;
      out_upd_in   = out_upd_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(magnitude(job_ff.delta)) * PROD_W'(cm_per_pulse);
            dist_in  = PROD_W'(magnitude(job_ff.count)) * PROD_W'(cm_per_pulse);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            sat_in = 1'b0;
            if (!job_ff.do_velocity) begin
               state_in = ST_DONE;
            end else if (scaled_hi >= HI_W'(job_ff.elapsed)) begin
               // The quotient does not fit in 32 bits.
               sat_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               rem_in   = scaled_hi[TIME_W-1:0];
               quo_in   = scaled[VEL_W-1:0];
               step_in  = STEP_W'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial[TIME_W-1:0] - job_ff.elapsed : trial[TIME_W-1:0];
            quo_in  = {quo_ff[VEL_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (job_ff.clear_velocity) begin
                  velocity_in = '0;
               end else if (job_ff.do_velocity) begin
                  velocity_in = vel_new;
               end
               out_valid_in = 1'b1;
               out_count_in = job_ff.count;
               out_vel_in   = job_ff.clear_velocity ? '0 :
                              (job_ff.do_velocity ? vel_new : velocity_ff);
               out_dist_in  = dist_sat;
               out_upd_in   = job_ff.do_velocity;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         velocity_ff  <= '0;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         velocity_ff  <= velocity_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      prod_ff      <= prod_in;
      dist_ff      <= dist_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      sat_ff       <= sat_in;
      out_count_ff <= out_count_in;
      out_vel_ff   <= out_vel_in;
      out_dist_ff  <= out_dist_in;
      out_upd_ff   <= out_upd_in;
   end

   assign empty                = !out_valid_ff;
   assign rsp_pulse_count      = out_count_ff;
   assign rsp_velocity         = out_vel_ff;
   assign rsp_distance         = out_dist_ff;
   assign rsp_velocity_updated = out_upd_ff;

   `WEP_ASSERT_NEXT(a_div_ends, clock, reset,
      state_ff == ST_DIV && step_ff == '0, state_ff == ST_DONE)
   `WEP_ASSERT_NEXT(a_result_waits, clock, reset,
      state_ff == ST_DONE && out_valid_ff && !pop, state_ff == ST_DONE)
   `WEP_ASSERT_SAME(a_result_source, clock, reset,
      $rose(out_valid_ff), $past(state_ff) == ST_DONE)

endmodule

@@ bench/tb_wheel_encoder_pulse_velocity.sv @@
// ----------------------------------------------------------------------------
// Testbench for wheel_encoder_pulse_velocity
// Drives encoder edges, velocity requests, counter resets and direction
// changes through the request queue and checks every response against a
// local predictor of the counter, the windowed velocity and the distance, or
// a typed row's reading. Directed rows cover glitch rejection, timestamp
// wrap, direction codes and velocity saturation. Random phases follow, each
// with its own register settings and random idle cycles on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wheel_encoder_pulse_velocity;
   import wep_pkg::*;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int PHASE_COUNT      = 8;
   localparam int ITEMS_PER_PHASE  = 194;
   localparam int SETTLE_CYCLES    = 40;
   localparam int REPORT_LIMIT     = 10;
   localparam int RESET_MIN_US     = 100;
   localparam int RESET_WINDOW_MS  = 50;
   localparam int RESET_CM         = 13107;
   localparam logic [1:0] DIR_MINUS_TWO = 2'b10;

   typedef enum logic {
      ROW_REQUEST,
      ROW_WRITE
   } row_kind_t;

   typedef struct packed {
      logic [COUNT_W-1:0] pulse_count;
      logic [VEL_W-1:0]   velocity;
      logic [DIST_W-1:0]  distance;
      logic               updated;
   } encoder_reading_t;

   typedef struct packed {
      row_kind_t          kind;
      action_type         action;
      logic [TIME_W-1:0]  now_us;
      logic [TIME_W-1:0]  now_ms;
      logic [1:0]         direction;
      csr_index_type      reg_index;
      logic [CSR_W-1:0]   reg_value;
      logic               typed;
      encoder_reading_t   gold;
   } stim_row_t;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic [1:0]                req_action = '0;
   logic [TIME_W-1:0]         req_now_us = '0;
   logic [TIME_W-1:0]         req_now_ms = '0;
   logic [1:0]                req_direction = '0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic signed [COUNT_W-1:0] rsp_pulse_count;
   logic signed [VEL_W-1:0]   rsp_velocity;
   logic signed [DIST_W-1:0]  rsp_distance;
   logic                      rsp_velocity_updated;
   logic                      csr_we = 1'b0;
   logic [1:0]                csr_index = '0;
   logic [CSR_W-1:0]          csr_wdata = '0;

   // Predictor copy of the registers and of the counter state.
   logic [MIN_W-1:0]    cfg_min = MIN_W'(RESET_MIN_US);
   logic [WINDOW_W-1:0] cfg_window = WINDOW_W'(RESET_WINDOW_MS);
   logic [CM_W-1:0]     cfg_cm = CM_W'(RESET_CM);
   logic [COUNT_W-1:0]  pred_count = '0;
   logic [1:0]          pred_dir = DIR_PLUS;
   logic [TIME_W-1:0]   pred_last_edge_us = '0;
   logic [COUNT_W-1:0]  pred_snapshot = '0;
   logic [TIME_W-1:0]   pred_last_ms = '0;
   logic [VEL_W-1:0]    pred_velocity = '0;

   encoder_reading_t expected_readings[$];
   int               mismatches = 0;
   int               readings_seen = 0;
   int               cycle_count;
   bit               send_idle = 1'b1;
   bit               recv_idle = 1'b1;

   stim_row_t directed_rows [0:28] = '{
      '{ROW_REQUEST, ACT_EDGE, 32'd0, 32'd0, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd0, 32'd0, 48'd0, 1'b0}},
      '{ROW_REQUEST, ACT_EDGE, 32'd100, 32'd0, DIR_MINUS_TWO, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd1, 32'd0, 48'd13107, 1'b0}},
      '{ROW_REQUEST, ACT_EDGE, 32'd150, 32'd0, DIR_ZERO, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd1, 32'd0, 48'd13107, 1'b0}},
      '{ROW_REQUEST, ACT_VELOCITY, 32'd150, 32'd49, DIR_MINUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd1, 32'd0, 48'd13107, 1'b0}},
      '{ROW_REQUEST, ACT_VELOCITY, 32'd150, 32'd50, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd1, 32'd262140, 48'd13107, 1'b1}},
      '{ROW_REQUEST, ACT_EDGE, 32'hFFFF_FFFF, 32'd50, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd2, 32'd262140, 48'd26214, 1'b0}},
      '{ROW_REQUEST, ACT_EDGE, 32'd99, 32'd50, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd3, 32'd262140, 48'd39321, 1'b0}},
      '{ROW_REQUEST, ACT_DIRECTION, 32'd99, 32'd50, DIR_MINUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_EDGE, 32'd200, 32'd50, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_DIRECTION, 32'd200, 32'd50, DIR_MINUS_TWO, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_EDGE, 32'd300, 32'd50, DIR_ZERO, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_EDGE, 32'd400, 32'd50, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_VELOCITY, 32'd400, 32'hFFFF_FFFF, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_DIRECTION, 32'd400, 32'hFFFF_FFFF, DIR_ZERO, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_EDGE, 32'd1000, 32'hFFFF_FFFF, DIR_MINUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_RESET, 32'd1000, 32'd5, DIR_MINUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd0, 32'd0, 48'd0, 1'b0}},
      '{ROW_REQUEST, ACT_VELOCITY, 32'd1000, 32'd54, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd0, 32'd0, 48'd0, 1'b0}},
      '{ROW_REQUEST, ACT_VELOCITY, 32'd1000, 32'd55, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd0, 32'd0, 48'd0, 1'b1}},
      '{ROW_REQUEST, ACT_DIRECTION, 32'd1000, 32'd55, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_WRITE, ACT_EDGE, 32'd0, 32'd0, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_WRITE, ACT_EDGE, 32'd0, 32'd0, DIR_PLUS, CSR_VELOCITY_WINDOW_MS, 24'd0,
        1'b0, '0},
      '{ROW_WRITE, ACT_EDGE, 32'd0, 32'd0, DIR_PLUS, CSR_CM_PER_PULSE, 24'hFF_FFFF,
        1'b0, '0},
      '{ROW_REQUEST, ACT_EDGE, 32'd5, 32'd55, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_VELOCITY, 32'd5, 32'd56, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd1, 32'h7FFF_FFFF, 48'hFF_FFFF, 1'b1}},
      '{ROW_REQUEST, ACT_VELOCITY, 32'd5, 32'd56, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'd1, 32'h7FFF_FFFF, 48'hFF_FFFF, 1'b0}},
      '{ROW_REQUEST, ACT_DIRECTION, 32'd5, 32'd56, DIR_MINUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_EDGE, 32'd5, 32'd56, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_EDGE, 32'd5, 32'd56, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b0, '0},
      '{ROW_REQUEST, ACT_VELOCITY, 32'd5, 32'd57, DIR_PLUS, CSR_MIN_EDGE_US, 24'd0,
        1'b1, '{32'hFFFF_FFFF, 32'h8000_0000, 48'hFFFF_FF00_0001, 1'b1}}
   };

   wheel_encoder_pulse_velocity dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_action           (req_action),
      .req_now_us           (req_now_us),
      .req_now_ms           (req_now_ms),
      .req_direction        (req_direction),
      .empty                (empty),
      .pop                  (pop),
      .rsp_pulse_count      (rsp_pulse_count),
      .rsp_velocity         (rsp_velocity),
      .rsp_distance         (rsp_distance),
      .rsp_velocity_updated (rsp_velocity_updated),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Velocity in Q16.16 cm/s: truncate the magnitude, apply the sign, saturate.
   function automatic logic [VEL_W-1:0] velocity_of(input logic [COUNT_W-1:0] delta,
                                                   input logic [TIME_W-1:0] elapsed);
      logic [63:0] product;
      logic [63:0] whole;
      logic [63:0] part;
      logic [63:0] scaled;
      product = {32'd0, delta[COUNT_W-1] ? ~delta + 32'd1 : delta} * {40'd0, cfg_cm};
      whole = product / {32'd0, elapsed};
      part = product % {32'd0, elapsed};
      if (whole >= 64'h1_0000_0000) begin
         scaled = 64'h1_0000_0000;
      end else begin
         scaled = whole * VEL_SCALE + (part * VEL_SCALE) / {32'd0, elapsed};
      end
      if (delta[COUNT_W-1]) begin
         if (scaled > 64'h8000_0000) scaled = 64'h8000_0000;
         return ~scaled[31:0] + 32'd1;
      end
      if (scaled > 64'h7FFF_FFFF) scaled = 64'h7FFF_FFFF;
      return scaled[31:0];
   endfunction

   function automatic logic [DIST_W-1:0] distance_of(input logic [COUNT_W-1:0] pulses);
      logic [63:0] travel;
      travel = {32'd0, pulses[COUNT_W-1] ? ~pulses + 32'd1 : pulses} * {40'd0, cfg_cm};
      if (pulses[COUNT_W-1]) begin
         if (travel > 64'h8000_0000_0000) travel = 64'h8000_0000_0000;
         travel = ~travel + 64'd1;
      end else if (travel > 64'h7FFF_FFFF_FFFF) begin
         travel = 64'h7FFF_FFFF_FFFF;
      end
      return travel[DIST_W-1:0];
   endfunction

   function automatic encoder_reading_t advance_encoder(input action_type act,
                                                        input logic [TIME_W-1:0] now_us,
                                                        input logic [TIME_W-1:0] now_ms,
                                                        input logic [1:0] dir);
      encoder_reading_t reading;
      logic [TIME_W-1:0] since_edge;
      logic [TIME_W-1:0] since_update;
      logic [TIME_W-1:0] window;
      reading.updated = 1'b0;
      case (act)
         ACT_EDGE: begin
            since_edge = now_us - pred_last_edge_us;
            if (since_edge >= {16'd0, cfg_min}) begin
               pred_last_edge_us = now_us;
               pred_count = pred_count + {{30{pred_dir[1]}}, pred_dir};
            end
         end
         ACT_VELOCITY: begin
            since_update = now_ms - pred_last_ms;
            window = (cfg_window == '0) ? 32'd1 : {16'd0, cfg_window};
            if (since_update >= window) begin
               pred_velocity = velocity_of(pred_count - pred_snapshot, since_update);
               pred_snapshot = pred_count;
               pred_last_ms = now_ms;
               reading.updated = 1'b1;
            end
         end
         ACT_RESET: begin
            pred_count = '0;
            pred_snapshot = '0;
            pred_last_ms = now_ms;
            pred_velocity = '0;
         end
         default: begin
            // Any code other than plus one or zero counts as a negative direction.
            if (dir == DIR_PLUS) pred_dir = DIR_PLUS;
            else if (dir == DIR_ZERO) pred_dir = DIR_ZERO;
            else pred_dir = DIR_MINUS;
         end
      endcase
      reading.pulse_count = pred_count;
      reading.velocity = pred_velocity;
      reading.distance = distance_of(pred_count);
      return reading;
   endfunction

   function automatic logic [CSR_W-1:0] pick_setting(input int unsigned low,
                                                    input int unsigned high);
      case ($urandom_range(0, 3))
         0: return CSR_W'(low);
         1: return CSR_W'(high);
         2: return CSR_W'($urandom_range(low, low + 200));
         default: return CSR_W'($urandom_range(low, high));
      endcase
   endfunction

   task automatic send_request(input action_type act, input logic [TIME_W-1:0] now_us,
                               input logic [TIME_W-1:0] now_ms, input logic [1:0] dir,
                               input logic typed, input encoder_reading_t gold);
      int gap;
      encoder_reading_t predicted;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      push = 1'b1;
      req_action = act;
      req_now_us = now_us;
      req_now_ms = now_ms;
      req_direction = dir;
      do @(posedge clock); while (full);
      predicted = advance_encoder(act, now_us, now_ms, dir);
      expected_readings.push_back(typed ? gold : predicted);
   endtask

   // Stop requesting and wait until every outstanding response has been popped.
   task automatic drain_requests();
      @(negedge clock);
      push = 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic program_register(input csr_index_type idx, input logic [CSR_W-1:0] value);
      drain_requests();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_MIN_EDGE_US: cfg_min = value[MIN_W-1:0];
         CSR_VELOCITY_WINDOW_MS: cfg_window = value[WINDOW_W-1:0];
         default: cfg_cm = value[CM_W-1:0];
      endcase
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_wheel_encoder_pulse_velocity failed");
      $finish;
   end

   // Response side: random stalls before each pop, then compare with the oldest prediction.
   initial begin
      int stall;
      encoder_reading_t seen;
      encoder_reading_t want;
      wait (reset == 1'b0);
      forever begin
         stall = recv_idle ? $urandom_range(0, 5) : 0;
         @(negedge clock);
         if (stall > 0) begin
            pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop = 1'b1;
         do @(posedge clock); while (empty);
         seen.pulse_count = rsp_pulse_count;
         seen.velocity = rsp_velocity;
         seen.distance = rsp_distance;
         seen.updated = rsp_velocity_updated;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("response %0d arrived with no request outstanding", readings_seen);
         end else begin
            want = expected_readings.pop_front();
            if (seen.pulse_count !== want.pulse_count || seen.velocity !== want.velocity ||
                seen.distance !== want.distance || seen.updated !== want.updated) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("response %0d: expected count %h velocity %h distance %h upd %b, got %h %h %h %b",
                           readings_seen, want.pulse_count, want.velocity, want.distance,
                           want.updated, seen.pulse_count, seen.velocity, seen.distance,
                           seen.updated);
            end
         end
         readings_seen++;
      end
   end

   initial begin
      action_type        act;
      logic [TIME_W-1:0] now_us;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] us_clock;
      logic [TIME_W-1:0] ms_clock;
      logic [1:0]        dir;
      logic [CSR_W-1:0]  min_set;
      logic [CSR_W-1:0]  window_set;
      logic [CSR_W-1:0]  cm_set;
      int                roll;

      repeat (3) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            program_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_request(directed_rows[i].action, directed_rows[i].now_us,
                         directed_rows[i].now_ms, directed_rows[i].direction,
                         directed_rows[i].typed, directed_rows[i].gold);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               min_set = CSR_W'(16'hFFFF);
               window_set = CSR_W'(16'hFFFF);
               cm_set = 24'hFF_FFFF;
            end
            1: begin
               min_set = '0;
               window_set = '0;
               cm_set = '0;
            end
            2: begin
               min_set = CSR_W'(RESET_MIN_US);
               window_set = CSR_W'(RESET_WINDOW_MS);
               cm_set = CSR_W'(RESET_CM);
            end
            default: begin
               min_set = pick_setting(0, 16'hFFFF);
               window_set = pick_setting(0, 16'hFFFF);
               cm_set = pick_setting(0, 24'hFF_FFFF);
            end
         endcase
         program_register(CSR_MIN_EDGE_US, min_set);
         program_register(CSR_VELOCITY_WINDOW_MS, window_set);
         program_register(CSR_CM_PER_PULSE, cm_set);

         send_idle = $urandom_range(0, 3) != 0;
         recv_idle = $urandom_range(0, 3) != 0;
         // Start either timestamp just below its wrap point in some phases.
         us_clock = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom;
         ms_clock = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            dir = 2'($urandom);
            if (roll < 5) begin
               act = action_type'(2'($urandom));
               now_us = $urandom;
               now_ms = $urandom;
            end else begin
               if (roll < 57) act = ACT_EDGE;
               else if (roll < 83) act = ACT_VELOCITY;
               else if (roll < 95) act = ACT_DIRECTION;
               else act = ACT_RESET;
               // Edge spacing straddles the glitch interval so both outcomes occur.
               if (act == ACT_EDGE) us_clock = us_clock + $urandom_range(0, 2 * cfg_min + 3);
               else us_clock = us_clock + $urandom_range(0, 20);
               ms_clock = ms_clock + $urandom_range(0, cfg_window / 4 + 1);
               if (act == ACT_DIRECTION && $urandom_range(0, 1) == 1) dir = DIR_PLUS;
               now_us = us_clock;
               now_ms = ms_clock;
            end
            send_request(act, now_us, now_ms, dir, 1'b0, '0);
         end
      end

      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("tb_wheel_encoder_pulse_velocity passed");
      end else begin
         $display("tb_wheel_encoder_pulse_velocity failed");
      end
      $finish;
   end

endmodule
